### src/gsnl_pkg.sv
// Shared widths, codes and handshake structs for the stencil neighbor lister.
package gsnl_pkg;

    localparam int NUM_W     = 12;   // cell numbers and grid indices
    localparam int SIZE_W    = 13;   // grid size registers
    localparam int AREA_W    = 2 * SIZE_W;   // size_x * size_y
    localparam int POS_W     = AREA_W + 1;   // neighbor positions, down side included
    localparam int ENTRY_W   = NUM_W + 1;    // map entry: active bit over cell number
    localparam int DIR_W     = 3;
    localparam int NDIR      = 7;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = $clog2(NUM_W + 1);

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
    localparam logic [DIR_W-1:0] DIR_BACK  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_SELF  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd4;
    localparam logic [DIR_W-1:0] DIR_FRONT = 3'd5;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd6;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  dividend;
        logic [AREA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
        logic [NUM_W-1:0] remainder;
    } div_rsp_t;

endpackage

### src/grid_stencil_neighbor_lister_core.sv
// Top level: cell map, coordinate split and seven-point neighbor listing.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------------------
//  input    | in_valid / in_stall      | operation, grid_index, entry_active, cell_number
//  output   | out_valid / out_stall    | neighbour_number, direction, slot, last
//  config   | cfg_we                   | cfg_index, cfg_data
//
// A write item leaves the block idle. A query runs one multiply, two
// 12-step divisions on the shared divider, seven map read slots on the single
// read port, then lists one entry per cycle while out_stall is low.
// in_stall is high while a query is in progress; the output register lets
// the next item in while the final entry still waits on out_stall.
// Reset clears control state and loads the size registers with 16; the
// map itself holds nothing defined until written.
module grid_stencil_neighbor_lister_core #(
    parameter int MAX_CELLS = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 operation,
    input  logic [gsnl_pkg::NUM_W-1:0]           grid_index,
    input  logic                                 entry_active,
    input  logic [gsnl_pkg::NUM_W-1:0]           cell_number,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [gsnl_pkg::NUM_W-1:0]           neighbour_number,
    output logic [gsnl_pkg::DIR_W-1:0]           direction,
    output logic [gsnl_pkg::DIR_W-1:0]           slot,
    output logic                                 last,
    input  logic                                 cfg_we,
    input  logic [gsnl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gsnl_pkg::SIZE_W-1:0]          cfg_data
);

    localparam int AW = $clog2(MAX_CELLS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_DIV1  = 3'd2;
    localparam logic [2:0] ST_DIV2  = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    localparam logic [gsnl_pkg::POS_W-1:0] POS_LIMIT = gsnl_pkg::POS_W'(MAX_CELLS);

    logic [2:0]                       state_reg;
    logic [gsnl_pkg::SIZE_W-1:0]      sx_reg;
    logic [gsnl_pkg::SIZE_W-1:0]      sy_reg;
    logic [gsnl_pkg::SIZE_W-1:0]      sz_reg;
    logic [gsnl_pkg::NUM_W-1:0]       g_reg;
    logic [gsnl_pkg::NUM_W-1:0]       own_reg;
    logic [gsnl_pkg::NUM_W-1:0]       k_reg;
    logic [gsnl_pkg::NUM_W-1:0]       j_reg;
    logic [gsnl_pkg::NUM_W-1:0]       i_reg;
    logic [gsnl_pkg::AREA_W-1:0]      nxny_reg;
    logic [gsnl_pkg::DIR_W-1:0]       dir_reg;
    logic                             pend_reg;
    logic [gsnl_pkg::DIR_W-1:0]       pend_dir_reg;
    logic [gsnl_pkg::NDIR-1:0]        hit_reg;
    logic [gsnl_pkg::NUM_W-1:0]       num_reg [gsnl_pkg::NDIR];
    logic [gsnl_pkg::DIR_W-1:0]       slot_reg;
    logic                             out_valid_reg;
    logic [gsnl_pkg::NUM_W-1:0]       out_num_reg;
    logic [gsnl_pkg::DIR_W-1:0]       out_dir_reg;
    logic [gsnl_pkg::DIR_W-1:0]       out_slot_reg;
    logic                             out_last_reg;

    logic [gsnl_pkg::SIZE_W-1:0]      nx;
    logic [gsnl_pkg::SIZE_W-1:0]      ny;
    logic [gsnl_pkg::SIZE_W-1:0]      nz;
    logic [gsnl_pkg::AREA_W-1:0]      nxny_prod;
    logic                             in_take;
    logic                             out_take;
    logic                             emit_load;
    logic [gsnl_pkg::DIR_W-1:0]       pick;
    logic [gsnl_pkg::NDIR-1:0]        hit_rest;
    logic [gsnl_pkg::POS_W-1:0]       g_wide;
    logic [gsnl_pkg::POS_W-1:0]       in_wide;
    logic [gsnl_pkg::POS_W-1:0]       pos;
    logic                             in_grid;
    logic                             rd_en;
    logic                             mem_we;
    logic [gsnl_pkg::ENTRY_W-1:0]     rdata;
    gsnl_pkg::div_req_t               div_req;
    gsnl_pkg::div_rsp_t               div_rsp;

    // A size register holding zero behaves as a size of one.
    assign nx = (sx_reg == '0) ? gsnl_pkg::SIZE_W'(1) : sx_reg;
    assign ny = (sy_reg == '0) ? gsnl_pkg::SIZE_W'(1) : sy_reg;
    assign nz = (sz_reg == '0) ? gsnl_pkg::SIZE_W'(1) : sz_reg;
    assign nxny_prod = {{gsnl_pkg::SIZE_W{1'b0}}, nx} * {{gsnl_pkg::SIZE_W{1'b0}}, ny};

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;

    assign in_wide = gsnl_pkg::POS_W'(grid_index);
    assign mem_we  = in_take && (operation == gsnl_pkg::OP_WRITE) && (in_wide < POS_LIMIT);

    // The first division gives z and the in-plane remainder, the second
    // splits that remainder into y and x.
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = div_rsp.remainder;
        div_req.divisor  = gsnl_pkg::AREA_W'(nx);
        if (state_reg == ST_MUL)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = g_reg;
            div_req.divisor  = nxny_prod;
        end
        else if (state_reg == ST_DIV1 && div_rsp.done)
        begin
            div_req.start = 1'b1;
        end
    end

    // Neighbor position and grid bounds for the direction under read.
    always_comb
    begin
        g_wide  = gsnl_pkg::POS_W'(g_reg);
        in_grid = 1'b0;
        pos     = g_wide;
        case (dir_reg)
            gsnl_pkg::DIR_UP:
            begin
                in_grid = (k_reg != '0);
                pos     = g_wide - gsnl_pkg::POS_W'(nxny_reg);
            end
            gsnl_pkg::DIR_BACK:
            begin
                in_grid = (j_reg != '0);
                pos     = g_wide - gsnl_pkg::POS_W'(nx);
            end
            gsnl_pkg::DIR_LEFT:
            begin
                in_grid = (i_reg != '0);
                pos     = g_wide - gsnl_pkg::POS_W'(1);
            end
            gsnl_pkg::DIR_RIGHT:
            begin
                in_grid = (gsnl_pkg::SIZE_W'(i_reg) + gsnl_pkg::SIZE_W'(1)) < nx;
                pos     = g_wide + gsnl_pkg::POS_W'(1);
            end
            gsnl_pkg::DIR_FRONT:
            begin
                in_grid = (gsnl_pkg::SIZE_W'(j_reg) + gsnl_pkg::SIZE_W'(1)) < ny;
                pos     = g_wide + gsnl_pkg::POS_W'(nx);
            end
            gsnl_pkg::DIR_DOWN:
            begin
                in_grid = (gsnl_pkg::SIZE_W'(k_reg) + gsnl_pkg::SIZE_W'(1)) < nz;
                pos     = g_wide + gsnl_pkg::POS_W'(nxny_reg);
            end
            default:
            begin
                in_grid = 1'b0;
                pos     = g_wide;
            end
        endcase
    end

    assign rd_en = (state_reg == ST_READ) && in_grid && (pos < POS_LIMIT);

    // Lowest remaining direction goes out first.
    always_comb
    begin
        pick = '0;
        for (int d = gsnl_pkg::NDIR - 1; d >= 0; d--)
        begin
            if (hit_reg[d])
            begin
                pick = gsnl_pkg::DIR_W'(d);
            end
        end
        hit_rest  = hit_reg & ~(gsnl_pkg::NDIR'(1) << pick);
        emit_load = (state_reg == ST_EMIT) && (hit_reg != '0) && (!out_valid_reg || !out_stall);
    end

    gsnl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    gsnl_ram #(
        .WIDTH (gsnl_pkg::ENTRY_W),
        .DEPTH (MAX_CELLS)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (in_wide[AW-1:0]),
        .wdata ({entry_active, cell_number}),
        .re    (rd_en),
        .raddr (pos[AW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= gsnl_pkg::SIZE_RESET;
            sy_reg <= gsnl_pkg::SIZE_RESET;
            sz_reg <= gsnl_pkg::SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gsnl_pkg::CFG_SIZE_X: sx_reg <= cfg_data;
                gsnl_pkg::CFG_SIZE_Y: sy_reg <= cfg_data;
                gsnl_pkg::CFG_SIZE_Z: sz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dir_reg       <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= rd_en;
            if (pend_reg && rdata[gsnl_pkg::ENTRY_W-1])
            begin
                hit_reg[pend_dir_reg] <= 1'b1;
            end

            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take && operation == gsnl_pkg::OP_QUERY)
                    begin
                        // The cell itself is always listed.
                        hit_reg   <= gsnl_pkg::NDIR'(1) << gsnl_pkg::DIR_SELF;
                        slot_reg  <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_DIV1;
                end
                ST_DIV1:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= ST_DIV2;
                    end
                end
                ST_DIV2:
                begin
                    if (div_rsp.done)
                    begin
                        dir_reg   <= gsnl_pkg::DIR_UP;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    dir_reg <= dir_reg + gsnl_pkg::DIR_W'(1);
                    if (dir_reg == gsnl_pkg::DIR_DOWN)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (emit_load)
                    begin
                        hit_reg  <= hit_rest;
                        slot_reg <= slot_reg + gsnl_pkg::DIR_W'(1);
                        if (hit_rest == '0)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            g_reg   <= grid_index;
            own_reg <= cell_number;
        end
        if (state_reg == ST_MUL)
        begin
            nxny_reg <= nxny_prod;
        end
        if (state_reg == ST_DIV1 && div_rsp.done)
        begin
            k_reg <= div_rsp.quotient;
        end
        if (state_reg == ST_DIV2 && div_rsp.done)
        begin
            j_reg <= div_rsp.quotient;
            i_reg <= div_rsp.remainder;
        end
        pend_dir_reg <= dir_reg;
        if (pend_reg)
        begin
            num_reg[pend_dir_reg] <= rdata[gsnl_pkg::NUM_W-1:0];
        end
        if (state_reg == ST_MUL)
        begin
            num_reg[gsnl_pkg::DIR_SELF] <= own_reg;
        end
        if (emit_load)
        begin
            out_num_reg  <= num_reg[pick];
            out_dir_reg  <= pick;
            out_slot_reg <= slot_reg;
            out_last_reg <= (hit_rest == '0);
        end
    end

    assign out_valid        = out_valid_reg;
    assign neighbour_number = out_num_reg;
    assign direction        = out_dir_reg;
    assign slot             = out_slot_reg;
    assign last             = out_last_reg;

`ifndef SYNTHESIS
    a_div_done_in_split: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV1 || state_reg == ST_DIV2))
        else $error("divider finished outside the coordinate split");

    a_emit_has_entries: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> hit_reg != '0)
        else $error("listing phase with an empty neighbor set");

    a_x_below_size: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> gsnl_pkg::SIZE_W'(i_reg) < nx)
        else $error("x coordinate not below size_x");

    a_no_read_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && rd_en))
        else $error("map written and read in the same cycle");
`endif

endmodule

### src/gsnl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module gsnl_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/gsnl_div.sv
// Restoring divider that produces one quotient bit per cycle.
module gsnl_div (
    input  logic                clk,
    input  logic                rst_n,
    input  gsnl_pkg::div_req_t  req,
    output gsnl_pkg::div_rsp_t  rsp
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [gsnl_pkg::STEP_W-1:0]  step_reg;
    logic [gsnl_pkg::NUM_W-1:0]   rem_reg;
    logic [gsnl_pkg::NUM_W-1:0]   quo_reg;
    logic [gsnl_pkg::AREA_W-1:0]  divisor_reg;

    logic [gsnl_pkg::NUM_W:0]     trial;
    logic [gsnl_pkg::AREA_W-1:0]  trial_wide;
    logic [gsnl_pkg::AREA_W-1:0]  diff;
    logic                         fits;
    logic [gsnl_pkg::NUM_W-1:0]   rem_step;

    // The partial remainder never exceeds the 12-bit dividend, so the top
    // bit of the trial value is always clear and truncation is safe.
    always_comb
    begin
        trial      = {rem_reg, quo_reg[gsnl_pkg::NUM_W-1]};
        trial_wide = gsnl_pkg::AREA_W'(trial);
        fits       = trial_wide >= divisor_reg;
        diff       = trial_wide - divisor_reg;
        rem_step   = fits ? diff[gsnl_pkg::NUM_W-1:0] : trial[gsnl_pkg::NUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg && req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= gsnl_pkg::STEP_W'(gsnl_pkg::NUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - gsnl_pkg::STEP_W'(1);
                if (step_reg == gsnl_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && req.start)
        begin
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[gsnl_pkg::NUM_W-2:0], fits};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
